FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// Types and constants of the pulse peak interval detector.
// ----------------------------------------------------------------------------
package ppid_pkg;

	localparam int IDX_W     = 32;
	localparam int RATE_W    = 16;
	localparam int IMS_W     = 16;
	localparam int MD_W      = 15;
	localparam int REG_IDX_W = 1;

	localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_INIT_TH     = 1'b1;

	localparam logic [RATE_W-1:0] RATE_RESET    = 16'd100;
	localparam logic [MD_W-1:0]   REFR_RST      = 15'd30;
	localparam int                INIT_TH_RESET = 100;

	// floor(x / 10) = (x * RECIP10) >> RECIP10_SH, exact for x < 2^18
	localparam logic [15:0] RECIP10    = 16'd52429;
	localparam int          RECIP10_SH = 19;

	// index difference times 1000 and the serial divider length
	localparam int DVD_W = IDX_W + 10;
	localparam int CNT_W = $clog2(DVD_W);

	typedef struct packed {
		logic             peak;
		logic             ivalid;
		logic [IDX_W-1:0] diff;
	} ppid_job_t;

endpackage

FILE: rtl/core/ppid_in_if.sv
// ----------------------------------------------------------------------------
// ppid_in_if
// Sample channel: valid/ready with sample and running index.
// ----------------------------------------------------------------------------
interface ppid_in_if #(
	parameter int SAMPLE_BITS = 18
);
	import ppid_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic [IDX_W-1:0]       sample_index;

	modport source (output valid, sample, sample_index, input ready);
	modport sink   (input valid, sample, sample_index, output ready);
endinterface

FILE: rtl/core/ppid_out_if.sv
// ----------------------------------------------------------------------------
// ppid_out_if
// Result channel: valid/ready with peak flag and beat interval.
// ----------------------------------------------------------------------------
interface ppid_out_if;
	import ppid_pkg::*;

	logic             valid;
	logic             ready;
	logic             peak_found;
	logic             interval_valid;
	logic [IMS_W-1:0] interval_ms;

	modport source (output valid, peak_found, interval_valid, interval_ms, input ready);
	modport sink   (input valid, peak_found, interval_valid, interval_ms, output ready);
endinterface

FILE: rtl/core/ppid_fifo.sv
// ----------------------------------------------------------------------------
// ppid_fifo
// Two-entry job queue between classifier and interval unit.
// ----------------------------------------------------------------------------
module ppid_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ppid_pkg::ppid_job_t push_job,
	output logic                full,
	input  logic                pop,
	output ppid_pkg::ppid_job_t pop_job,
	output logic                not_empty
);
	import ppid_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	ppid_job_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/core/ppid_front.sv
// ----------------------------------------------------------------------------
// ppid_front
// Config registers, arming and peak classification, threshold update.
// ----------------------------------------------------------------------------
module ppid_front #(
	parameter  int SAMPLE_BITS = 18,
	localparam int CFG_W = (SAMPLE_BITS - 1 > ppid_pkg::RATE_W) ?
	                       SAMPLE_BITS - 1 : ppid_pkg::RATE_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ppid_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]                   cfg_wdata,
	ppid_in_if.sink                            samples,
	output logic                               push,
	output ppid_pkg::ppid_job_t                push_job,
	input  logic                               fifo_full,
	output logic [ppid_pkg::RATE_W-1:0]        rate
);
	import ppid_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int TH_W  = SB + 8;
	localparam int SUM_W = TH_W + 3;
	localparam int K     = SUM_W + 2;
	localparam longint RECIP5_L = ((64'sd1 <<< K) + 64'sd4) / 5;
	localparam logic [SUM_W-1:0] RECIP5 = SUM_W'(RECIP5_L);

	localparam logic F_IDLE = 1'b0;
	localparam logic F_TH   = 1'b1;

	logic                 state_q;
	logic [RATE_W-1:0]    rate_q;
	logic [MD_W-1:0]      md_q;
	logic [TH_W-1:0]      th_q;
	logic [SUM_W-1:0]     sum_q;
	logic [IDX_W-1:0]     last_q;
	logic                 armed_q;
	logic                 seen_q;
	logic signed [SB-1:0] prev_q;
	logic                 prev_rising_q;

	logic signed [SB-1:0] s;
	logic                 rising;
	logic [IDX_W-1:0]     diff;
	logic                 above;
	logic                 arm_now;
	logic                 peak;
	logic [SB-1:0]        mag;
	logic [SUM_W-1:0]     sum;
	logic [2*SUM_W-1:0]   prod;
	logic                 accept;
	logic [RATE_W-1:0]    wr_rate;
	logic [17:0]          wr_rate3;
	logic [33:0]          md_prod;

	assign s       = $signed(samples.sample);
	assign rising  = s > prev_q;
	assign diff    = samples.sample_index - last_q;
	assign above   = !s[SB-1] && ({1'b0, samples.sample[SB-2:0], 8'h00} > th_q);
	assign arm_now = !armed_q && above && rising && (!seen_q || diff > IDX_W'(md_q));
	assign peak    = (armed_q || arm_now) && prev_rising_q && !rising;
	assign mag     = s[SB-1] ? (~samples.sample + 1'b1) : samples.sample;
	assign sum     = SUM_W'({th_q, 2'b00}) + SUM_W'({mag, 8'h00});
	assign prod    = (2*SUM_W)'(sum_q) * (2*SUM_W)'(RECIP5);

	assign samples.ready = (state_q == F_IDLE) && !fifo_full;
	assign accept        = samples.valid && samples.ready;
	assign push          = accept;
	assign push_job      = '{peak: peak, ivalid: peak && seen_q, diff: diff};
	assign rate          = rate_q;

	// rate of zero counts as one; refractory span floor(3 * rate / 10)
	assign wr_rate  = (cfg_wdata[RATE_W-1:0] == '0) ? RATE_W'(1) : cfg_wdata[RATE_W-1:0];
	assign wr_rate3 = {1'b0, wr_rate, 1'b0} + 18'(wr_rate);
	assign md_prod  = 34'(wr_rate3) * 34'(RECIP10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			rate_q        <= RATE_RESET;
			md_q          <= REFR_RST;
			th_q          <= TH_W'(INIT_TH_RESET) << 8;
			sum_q         <= '0;
			last_q        <= '0;
			armed_q       <= 1'b0;
			seen_q        <= 1'b0;
			prev_q        <= '0;
			prev_rising_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						prev_q        <= s;
						prev_rising_q <= rising;
						if (peak) begin
							armed_q <= 1'b0;
							seen_q  <= 1'b1;
							last_q  <= samples.sample_index;
							sum_q   <= sum;
							state_q <= F_TH;
						end else begin
							armed_q <= armed_q || arm_now;
						end
					end
				end
				F_TH: begin
					th_q    <= prod[K +: TH_W];
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_addr)
					REG_SAMPLE_RATE: begin
						rate_q <= wr_rate;
						md_q   <= md_prod[RECIP10_SH +: MD_W];
					end
					REG_INIT_TH: th_q <= {1'b0, cfg_wdata[SB-2:0], 8'h00};
					default: ;
				endcase
			end
		end
	end
endmodule

FILE: rtl/core/ppid_back.sv
// ----------------------------------------------------------------------------
// ppid_back
// Beat interval unit: serial divide of difference * 1000 by the rate.
// ----------------------------------------------------------------------------
module ppid_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ppid_pkg::ppid_job_t         job,
	input  logic                        job_valid,
	output logic                        job_pop,
	input  logic [ppid_pkg::RATE_W-1:0] rate,
	ppid_out_if.source                  results
);
	import ppid_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_HOLD = 2'd2;

	logic [1:0]        state_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [RATE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovalid_q;
	logic              peak_q;
	logic              iv_q;
	logic [IMS_W-1:0]  ms_q;

	logic              out_free;
	logic              ovalid_set;
	logic [DVD_W-1:0]  dvd_load;
	logic [RATE_W:0]   shifted;
	logic [RATE_W:0]   trial;
	logic              ge;
	logic [IMS_W-1:0]  sat;

	assign out_free   = !ovalid_q || results.ready;
	assign job_pop    = (state_q == B_IDLE) && job_valid && (job.ivalid || out_free);
	assign ovalid_set = (job_pop && !job.ivalid) || ((state_q == B_HOLD) && out_free);
	assign dvd_load = (DVD_W'(job.diff) << 10) - (DVD_W'(job.diff) << 4) -
	                  (DVD_W'(job.diff) << 3);
	assign shifted  = {rem_q, dvd_q[DVD_W-1]};
	assign trial    = shifted - {1'b0, rate};
	assign ge       = shifted >= {1'b0, rate};
	assign sat      = (|dvd_q[DVD_W-1:IMS_W]) ? '1 : dvd_q[IMS_W-1:0];

	assign results.valid          = ovalid_q;
	assign results.peak_found     = peak_q;
	assign results.interval_valid = iv_q;
	assign results.interval_ms    = ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			dvd_q    <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
			peak_q   <= 1'b0;
			iv_q     <= 1'b0;
			ms_q     <= '0;
		end else begin
			if (ovalid_set) begin
				ovalid_q <= 1'b1;
			end else if (results.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						if (job.ivalid) begin
							dvd_q   <= dvd_load;
							rem_q   <= '0;
							cnt_q   <= CNT_W'(DVD_W - 1);
							state_q <= B_DIV;
						end else begin
							peak_q   <= job.peak;
							iv_q     <= 1'b0;
							ms_q     <= '0;
						end
					end
				end
				B_DIV: begin
					dvd_q <= {dvd_q[DVD_W-2:0], ge};
					rem_q <= ge ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
					if (cnt_q == '0) begin
						state_q <= B_HOLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				B_HOLD: begin
					if (out_free) begin
						peak_q   <= 1'b1;
						iv_q     <= 1'b1;
						ms_q     <= sat;
						state_q  <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/core/pulse_peak_interval_detector.sv
// ----------------------------------------------------------------------------
// pulse_peak_interval_detector
// Adaptive threshold pulse peak detector with refractory span and beat
// interval in milliseconds.
// ----------------------------------------------------------------------------
// channel   dir  beat contents
// samples   in   sample, sample_index
// results   out  peak_found, interval_valid, interval_ms
// cfg       in   write enable, register index, data (no read-back)
//
// A sample that is not a peak is classified and queued directly; a peak then
// holds the classifier in the threshold update state (divide-by-five multiply).
// A peak with an earlier peak passes the interval unit's one-bit-per-cycle
// divider over 42 dividend bits, then its hold state; other beats skip both.
// A two-entry queue lets the classifier run ahead while the divider or the
// result register stalls. Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
module pulse_peak_interval_detector #(
	parameter  int SAMPLE_BITS = 18,
	localparam int CFG_W = (SAMPLE_BITS - 1 > ppid_pkg::RATE_W) ?
	                       SAMPLE_BITS - 1 : ppid_pkg::RATE_W
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppid_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]               cfg_wdata,
	ppid_in_if.sink                        samples,
	ppid_out_if.source                     results
);
	import ppid_pkg::*;

	logic              push;
	ppid_job_t         push_job;
	logic              fifo_full;
	logic              pop;
	ppid_job_t         pop_job;
	logic              not_empty;
	logic [RATE_W-1:0] rate;

	ppid_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.samples   (samples),
		.push      (push),
		.push_job  (push_job),
		.fifo_full (fifo_full),
		.rate      (rate)
	);

	ppid_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (fifo_full),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (not_empty)
	);

	ppid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.job_valid (not_empty),
		.job_pop   (pop),
		.rate      (rate),
		.results   (results)
	);
endmodule

FILE: rtl/core/ppid_checker.sv
// ----------------------------------------------------------------------------
// ppid_checker
// Port-level checks on the result channel of the detector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppid_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        r_valid,
	input logic                        r_ready,
	input logic                        r_peak,
	input logic                        r_iv,
	input logic [ppid_pkg::IMS_W-1:0]  r_ms
);
	`ASSERT_NEXT(a_valid_holds, clk, arst_n, r_valid && !r_ready, r_valid)
	`ASSERT_NEXT(a_ms_holds, clk, arst_n, r_valid && !r_ready, $stable(r_ms))
	`ASSERT_IMPL(a_interval_is_peak, clk, arst_n, r_valid && r_iv, r_peak)
	`ASSERT_IMPL(a_ms_zero_no_iv, clk, arst_n, r_valid && !r_iv, r_ms == '0)
endmodule

bind pulse_peak_interval_detector ppid_checker u_ppid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.r_valid (results.valid),
	.r_ready (results.ready),
	.r_peak  (results.peak_found),
	.r_iv    (results.interval_valid),
	.r_ms    (results.interval_ms)
);
